@@ rtl/tog_pkg.sv @@
// ----------------------------------------------------------------------------
// tog_pkg
// Shared types and constants of the tensor offset generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tog_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned OFFSET_W = 64;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Layout codes. The fourth code behaves exactly like row-major.
  typedef enum logic [1:0] {
    LAYOUT_ROW     = 2'd0,
    LAYOUT_COL     = 2'd1,
    LAYOUT_TILED   = 2'd2,
    LAYOUT_ROW_ALT = 2'd3
  } layout_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LAYOUT = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/tog_ifs.sv @@
// ----------------------------------------------------------------------------
// tog channel interfaces
// Valid/ready channels for coordinate items and offset results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tog_coord_if;
  logic                         valid;
  logic                         ready;
  logic [tog_pkg::COORD_W-1:0]  col_x;
  logic [tog_pkg::COORD_W-1:0]  row_y;
  logic [tog_pkg::COORD_W-1:0]  plane_z;

  modport source (output valid, output col_x, output row_y, output plane_z, input ready);
  modport sink   (input valid, input col_x, input row_y, input plane_z, output ready);
endinterface

interface tog_offset_if;
  logic                         valid;
  logic                         ready;
  logic [tog_pkg::OFFSET_W-1:0] elem_offset;
  logic                         out_of_range;

  modport source (output valid, output elem_offset, output out_of_range, input ready);
  modport sink   (input valid, input elem_offset, input out_of_range, output ready);
endinterface

`default_nettype wire

@@ rtl/tensor_offset_generator.sv @@
// Pipeline: five register stages; a coordinate item passes stages 1 to 4 and
// then the output register before its result is presented.
// Throughput: one item per cycle unless the output stalls; the depth is set by
// the 32x32 partial products of the plane base multiply in the second stage.
// Reset: synchronous, active low; clears all stage valid bits and the
// configuration registers (width 0, height 0, row-major).
// ----------------------------------------------------------------------------
// tensor_offset_generator
// Maps (x, y, plane) to a linear element offset for row-major, column-major
// or 4x4 tiled tensors, flagging bounds violations and 64-bit overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_offset_generator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tog_pkg::CFG_W-1:0]      cfg_wdata,
  tog_coord_if.sink                           in_chan,
  tog_offset_if.source                        out_chan
);

  // Configuration registers
  logic [31:0]      width_r;
  logic [31:0]      height_r;
  tog_pkg::layout_t layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      layout_r <= tog_pkg::LAYOUT_ROW;
    end else if (cfg_we) begin
      unique case (tog_pkg::cfg_reg_t'(cfg_index))
        tog_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        tog_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        tog_pkg::REG_LAYOUT: layout_r <= tog_pkg::layout_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  logic is_tiled, is_col;
  assign is_tiled = (layout_r == tog_pkg::LAYOUT_TILED);
  assign is_col   = (layout_r == tog_pkg::LAYOUT_COL);

  // Pipeline enables: a stage loads when it is empty or its content moves on.
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic en1, en2, en3, en4, en5;
  assign en5 = !vo_r || out_chan.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_chan.ready = en1;

  // ---------------- Stage 1: bounds, plane sizes, row/column product -------
  logic [32:0] wb_sum, hb_sum;
  logic [30:0] wb, hb;
  logic [31:0] mul_a, mul_b, minor_nxt;
  logic        bad1_nxt;

  assign wb_sum = {1'b0, width_r} + 33'd3;
  assign hb_sum = {1'b0, height_r} + 33'd3;
  assign wb     = wb_sum[32:2];
  assign hb     = hb_sum[32:2];
  assign bad1_nxt = (in_chan.col_x >= width_r) || (in_chan.row_y >= height_r);

  always_comb begin
    if (is_tiled) begin
      mul_a     = {2'b00, in_chan.row_y[31:2]};
      mul_b     = {1'b0, wb};
      minor_nxt = {2'b00, in_chan.col_x[31:2]};
    end else if (is_col) begin
      mul_a     = in_chan.col_x;
      mul_b     = height_r;
      minor_nxt = in_chan.row_y;
    end else begin
      mul_a     = in_chan.row_y;
      mul_b     = width_r;
      minor_nxt = in_chan.col_x;
    end
  end

  logic        bad1_r, tiled1_r;
  logic [31:0] z1_r, minor1_r;
  logic [63:0] plane1_r, prod1_r;
  logic [60:0] ppl1_r;
  logic [3:0]  lo1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en1) v1_r <= in_chan.valid;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r   <= bad1_nxt;
      tiled1_r <= is_tiled;
      z1_r     <= in_chan.plane_z;
      minor1_r <= minor_nxt;
      plane1_r <= {32'd0, width_r} * {32'd0, height_r};
      ppl1_r   <= 61'({30'd0, wb} * {30'd0, hb});
      prod1_r  <= {32'd0, mul_a} * {32'd0, mul_b};
      lo1_r    <= {in_chan.row_y[1:0], in_chan.col_x[1:0]};
    end
  end

  // ---------------- Stage 2: partial products of the plane bases -----------
  logic        bad2_r, tiled2_r;
  logic [31:0] minor2_r;
  logic [63:0] zp_lo2_r, zp_hi2_r, zq_lo2_r, zq_hi2_r, prod2_r;
  logic [3:0]  lo2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en2) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      bad2_r   <= bad1_r;
      tiled2_r <= tiled1_r;
      minor2_r <= minor1_r;
      prod2_r  <= prod1_r;
      lo2_r    <= lo1_r;
      zp_lo2_r <= {32'd0, z1_r} * {32'd0, plane1_r[31:0]};
      zp_hi2_r <= {32'd0, z1_r} * {32'd0, plane1_r[63:32]};
      zq_lo2_r <= {32'd0, z1_r} * {32'd0, ppl1_r[31:0]};
      zq_hi2_r <= {32'd0, z1_r} * {35'd0, ppl1_r[60:32]};
    end
  end

  // ---------------- Stage 3: combine partial products, base overflow ------
  logic [95:0] zp_sum, zq_sum;
  logic        zp_ovf, zq_ovf;

  assign zp_sum = {32'd0, zp_lo2_r} + {zp_hi2_r, 32'd0};
  assign zq_sum = {32'd0, zq_lo2_r} + {zq_hi2_r, 32'd0};
  assign zp_ovf = (zp_sum[95:64] != 32'd0);
  assign zq_ovf = (zq_sum[95:64] != 32'd0);

  logic        bad3_r, tiled3_r;
  logic [31:0] minor3_r;
  logic [63:0] base3_r, prod3_r;
  logic [3:0]  lo3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en3) v3_r <= v2_r;
  end

  // The full plane base is checked for overflow in every layout, tiled included.
  always_ff @(posedge clk) begin
    if (en3) begin
      bad3_r   <= bad2_r || zp_ovf || (tiled2_r && zq_ovf);
      tiled3_r <= tiled2_r;
      minor3_r <= minor2_r;
      prod3_r  <= prod2_r;
      lo3_r    <= lo2_r;
      base3_r  <= tiled2_r ? zq_sum[63:0] : zp_sum[63:0];
    end
  end

  // ---------------- Stage 4: base plus major term -------------------------
  logic [64:0] t_sum;
  assign t_sum = {1'b0, base3_r} + {1'b0, prod3_r};

  logic        bad4_r, tiled4_r;
  logic [31:0] minor4_r;
  logic [63:0] t4_r;
  logic [3:0]  lo4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en4) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      bad4_r   <= bad3_r || t_sum[64];
      tiled4_r <= tiled3_r;
      minor4_r <= minor3_r;
      t4_r     <= t_sum[63:0];
      lo4_r    <= lo3_r;
    end
  end

  // ---------------- Stage 5: minor term, tile expansion, output register --
  logic [64:0] r_sum;
  logic        bad5;
  logic [63:0] off5;

  assign r_sum = {1'b0, t4_r} + {33'd0, minor4_r};

  // A block index that does not survive the shift by four is an overflow.
  always_comb begin
    bad5 = bad4_r || r_sum[64];
    if (tiled4_r) begin
      bad5 = bad5 || (r_sum[63:60] != 4'd0);
      off5 = {r_sum[59:0], lo4_r};
    end else begin
      off5 = r_sum[63:0];
    end
  end

  logic [63:0] offset_r;
  logic        oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en5) vo_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      offset_r <= bad5 ? 64'd0 : off5;
      oor_r    <= bad5;
    end
  end

  assign out_chan.valid        = vo_r;
  assign out_chan.elem_offset  = offset_r;
  assign out_chan.out_of_range = oor_r;

endmodule

`default_nettype wire
